### rtl/qvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants and types for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_BITS_DEF = 16;
    localparam int VEC_BITS_DEF  = 16;
    localparam int LANES         = 3;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
    } qvr_flags_t;

endpackage

### rtl/qvr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_in_if / qvr_out_if
// Valid/ready channels for rotation requests and rotated results.
// ----------------------------------------------------------------------------
interface qvr_in_if #(
    parameter int QUAT_BITS = 16,
    parameter int VEC_BITS  = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
    logic signed [VEC_BITS-1:0]  vec_x;
    logic signed [VEC_BITS-1:0]  vec_y;
    logic signed [VEC_BITS-1:0]  vec_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                    output ready);
endinterface

interface qvr_out_if #(
    parameter int VEC_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [VEC_BITS-1:0] rot_x;
    logic signed [VEC_BITS-1:0] rot_y;
    logic signed [VEC_BITS-1:0] rot_z;
    logic                       clipped;
    logic                       zero_norm;

    modport source (output valid, rot_x, rot_y, rot_z, clipped, zero_norm, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, clipped, zero_norm, output ready);
endinterface

### rtl/qvr_prod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_prod
// Four-stage Hamilton product pipeline: r = q * v * conj(q), n = |q|^2,
// then sign split and rounding numerator/denominator for the divider.
// ----------------------------------------------------------------------------
module qvr_prod #(
    parameter int QUAT_BITS = 16,
    parameter int VEC_BITS  = 16,
    parameter int NW        = 2 * QUAT_BITS + 1,
    parameter int DW        = 2 * QUAT_BITS + VEC_BITS + 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [QUAT_BITS-1:0]  q_w,
    input  logic signed [QUAT_BITS-1:0]  q_x,
    input  logic signed [QUAT_BITS-1:0]  q_y,
    input  logic signed [QUAT_BITS-1:0]  q_z,
    input  logic signed [VEC_BITS-1:0]   v_x,
    input  logic signed [VEC_BITS-1:0]   v_y,
    input  logic signed [VEC_BITS-1:0]   v_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0][DW-1:0]           out_num,
    output logic [NW:0]                  out_den,
    output qvr_pkg::qvr_flags_t          out_flags
);
    import qvr_pkg::*;

    localparam int QV = QUAT_BITS + VEC_BITS;
    localparam int PW = QV + 2;
    localparam int PQ = PW + QUAT_BITS;
    localparam int RW = PQ + 2;
    localparam int SQ = 2 * QUAT_BITS;

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic adv1, adv2, adv3, adv4;

    logic signed [QUAT_BITS-1:0] q_in [4];
    logic signed [VEC_BITS-1:0]  v_in [3];

    logic signed [QV-1:0]        s1_qv_reg [4][3];
    logic signed [SQ-1:0]        s1_sq_reg [4];
    logic signed [QUAT_BITS-1:0] s1_q_reg  [4];
    logic                        s1_zero_reg;

    logic signed [PW-1:0]        s2_p_reg [4];
    logic signed [PW-1:0]        s2_p_next [4];
    logic [NW-1:0]               s2_n_reg;
    logic [NW-1:0]               s2_n_next;
    logic signed [QUAT_BITS-1:0] s2_q_reg [4];
    logic                        s2_zero_reg;

    logic signed [PQ-1:0]        s3_pq_reg [4][4];
    logic [NW-1:0]               s3_n_reg;
    logic                        s3_zero_reg;

    logic signed [RW-1:0]        r_next [3];
    logic [2:0][DW-1:0]          s4_num_reg;
    logic [2:0][DW-1:0]          s4_num_next;
    logic [NW:0]                 s4_den_reg;
    qvr_flags_t                  s4_flags_reg;
    logic [2:0]                  neg_next;

    assign adv4 = !s4_v_reg || out_ready;
    assign adv3 = !s3_v_reg || adv4;
    assign adv2 = !s2_v_reg || adv3;
    assign adv1 = !s1_v_reg || adv2;
    assign in_ready = adv1;

    assign q_in[0] = q_w;
    assign q_in[1] = q_x;
    assign q_in[2] = q_y;
    assign q_in[3] = q_z;
    assign v_in[0] = v_x;
    assign v_in[1] = v_y;
    assign v_in[2] = v_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_v_reg <= in_valid;
            if (adv2)
                s2_v_reg <= s1_v_reg;
            if (adv3)
                s3_v_reg <= s2_v_reg;
            if (adv4)
                s4_v_reg <= s3_v_reg;
        end
    end

    // stage 1: q*v cross products and squares
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 3; j++)
                    s1_qv_reg[i][j] <= q_in[i] * v_in[j];
                s1_sq_reg[i] <= q_in[i] * q_in[i];
                s1_q_reg[i]  <= q_in[i];
            end
            s1_zero_reg <= (q_w == '0) && (q_x == '0) && (q_y == '0) && (q_z == '0);
        end
    end

    // stage 2: p = q * (0, v) and the squared norm
    always_comb
    begin
        s2_p_next[0] = -PW'(s1_qv_reg[1][0]) - PW'(s1_qv_reg[2][1]) - PW'(s1_qv_reg[3][2]);
        s2_p_next[1] = PW'(s1_qv_reg[0][0]) + PW'(s1_qv_reg[2][2]) - PW'(s1_qv_reg[3][1]);
        s2_p_next[2] = PW'(s1_qv_reg[0][1]) - PW'(s1_qv_reg[1][2]) + PW'(s1_qv_reg[3][0]);
        s2_p_next[3] = PW'(s1_qv_reg[0][2]) + PW'(s1_qv_reg[1][1]) - PW'(s1_qv_reg[2][0]);
        s2_n_next = NW'(unsigned'(s1_sq_reg[0])) + NW'(unsigned'(s1_sq_reg[1]))
                  + NW'(unsigned'(s1_sq_reg[2])) + NW'(unsigned'(s1_sq_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_v_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s2_p_reg[i] <= s2_p_next[i];
                s2_q_reg[i] <= s1_q_reg[i];
            end
            s2_n_reg    <= s2_n_next;
            s2_zero_reg <= s1_zero_reg;
        end
    end

    // stage 3: p * conj(q) partial products
    always_ff @(posedge clk)
    begin
        if (adv3 && s2_v_reg)
        begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    s3_pq_reg[i][j] <= s2_p_reg[i] * s2_q_reg[j];
            s3_n_reg    <= s2_n_reg;
            s3_zero_reg <= s2_zero_reg;
        end
    end

    // stage 4: sum, split sign, form 2|r|+n
    always_comb
    begin
        r_next[0] = RW'(s3_pq_reg[1][0]) - RW'(s3_pq_reg[0][1])
                  - RW'(s3_pq_reg[2][3]) + RW'(s3_pq_reg[3][2]);
        r_next[1] = RW'(s3_pq_reg[2][0]) - RW'(s3_pq_reg[0][2])
                  + RW'(s3_pq_reg[1][3]) - RW'(s3_pq_reg[3][1]);
        r_next[2] = RW'(s3_pq_reg[3][0]) - RW'(s3_pq_reg[0][3])
                  - RW'(s3_pq_reg[1][2]) + RW'(s3_pq_reg[2][1]);
        for (int k = 0; k < 3; k++)
        begin
            neg_next[k]    = r_next[k][RW-1];
            s4_num_next[k] = {(neg_next[k] ? -r_next[k] : r_next[k]), 1'b0}
                           + DW'(s3_n_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && s3_v_reg)
        begin
            s4_num_reg        <= s4_num_next;
            s4_den_reg        <= {s3_n_reg, 1'b0};
            s4_flags_reg.neg  <= neg_next;
            s4_flags_reg.zero <= s3_zero_reg;
        end
    end

    assign out_valid = s4_v_reg;
    assign out_num   = s4_num_reg;
    assign out_den   = s4_den_reg;
    assign out_flags = s4_flags_reg;

endmodule

### rtl/qvr_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_div_stage
// One restoring-division step for three lanes sharing one divisor.
// ----------------------------------------------------------------------------
module qvr_div_stage #(
    parameter int DW   = 53,
    parameter int NW   = 33,
    parameter int QB   = 18,
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0][DW-1:0]  in_rem,
    input  logic [2:0][QB-1:0]  in_quo,
    input  logic [NW:0]         in_den,
    input  qvr_pkg::qvr_flags_t in_flags,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0][DW-1:0]  out_rem,
    output logic [2:0][QB-1:0]  out_quo,
    output logic [NW:0]         out_den,
    output qvr_pkg::qvr_flags_t out_flags
);
    import qvr_pkg::*;

    logic               v_reg;
    logic               adv;
    logic [DW-1:0]      den_sh;
    logic [DW:0]        trial [3];
    logic [2:0][DW-1:0] rem_reg, rem_next;
    logic [2:0][QB-1:0] quo_reg, quo_next;
    logic [NW:0]        den_reg;
    qvr_flags_t         flags_reg;

    assign adv      = !v_reg || out_ready;
    assign in_ready = adv;
    assign den_sh   = DW'(in_den) << STEP;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            trial[k]    = {1'b0, in_rem[k]} - {1'b0, den_sh};
            rem_next[k] = trial[k][DW] ? in_rem[k] : trial[k][DW-1:0];
            quo_next[k] = in_quo[k];
            quo_next[k][STEP] = !trial[k][DW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (adv)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            den_reg   <= in_den;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_flags = flags_reg;

endmodule

### rtl/quaternion_vector_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotator
// Rotates a vector by a quaternion: q * v * q^-1, rounded and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: quaternion (Q1.14) and a 3-vector. res returns
//   the rotated vector in the input vector's scale, with clipped set when a
//   component saturated and zero_norm set (vector forced to zero) when the
//   quaternion is all zero. Both channels are valid/ready.
//   One request is taken per cycle while no stage is stalled. The pipeline
//   has four product/sum stages, VEC_BITS + 2 restoring division stages
//   (one quotient bit each), and one rounding/saturation output register.
//   Each stage holds while the next is full and stalled, so a stalled
//   receiver backs up the pipeline one stage at a time; bubbles are filled
//   and req.ready stays high until every stage holds a request.
//   Reset clears all valid bits; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module quaternion_vector_rotator #(
    parameter int QUAT_BITS = qvr_pkg::QUAT_BITS_DEF,
    parameter int VEC_BITS  = qvr_pkg::VEC_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    qvr_in_if.sink    req,
    qvr_out_if.source res
);
    import qvr_pkg::*;

    localparam int NW = 2 * QUAT_BITS + 1;
    localparam int DW = 2 * QUAT_BITS + VEC_BITS + 5;
    localparam int QB = VEC_BITS + 2;

    logic               c_valid [QB+1];
    logic               c_ready [QB+1];
    logic [2:0][DW-1:0] c_rem   [QB+1];
    logic [2:0][QB-1:0] c_quo   [QB+1];
    logic [NW:0]        c_den   [QB+1];
    qvr_flags_t         c_flags [QB+1];

    logic                             o_v_reg;
    logic                             o_adv;
    logic signed [2:0][VEC_BITS-1:0]  rot_reg, rot_next;
    logic                             clip_reg, clip_next;
    logic                             zero_reg;
    logic [QB-1:0]                    lim_pos, lim_neg, lim;
    logic [QB-1:0]                    mag;
    logic [2:0]                       sat;

    qvr_prod #(
        .QUAT_BITS (QUAT_BITS),
        .VEC_BITS  (VEC_BITS),
        .NW        (NW),
        .DW        (DW)
    ) u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .q_w       (req.quat_w),
        .q_x       (req.quat_x),
        .q_y       (req.quat_y),
        .q_z       (req.quat_z),
        .v_x       (req.vec_x),
        .v_y       (req.vec_y),
        .v_z       (req.vec_z),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_num   (c_rem[0]),
        .out_den   (c_den[0]),
        .out_flags (c_flags[0])
    );

    assign c_quo[0] = '0;

    genvar g;
    generate
        for (g = 0; g < QB; g++)
        begin : g_div
            qvr_div_stage #(
                .DW   (DW),
                .NW   (NW),
                .QB   (QB),
                .STEP (QB - 1 - g)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (c_valid[g]),
                .in_ready  (c_ready[g]),
                .in_rem    (c_rem[g]),
                .in_quo    (c_quo[g]),
                .in_den    (c_den[g]),
                .in_flags  (c_flags[g]),
                .out_valid (c_valid[g+1]),
                .out_ready (c_ready[g+1]),
                .out_rem   (c_rem[g+1]),
                .out_quo   (c_quo[g+1]),
                .out_den   (c_den[g+1]),
                .out_flags (c_flags[g+1])
            );
        end
    endgenerate

    assign o_adv       = !o_v_reg || res.ready;
    assign c_ready[QB] = o_adv;
    assign lim_pos     = {{(QB - VEC_BITS + 1){1'b0}}, {(VEC_BITS - 1){1'b1}}};
    assign lim_neg     = lim_pos + QB'(1);

    always_comb
    begin
        clip_next = 1'b0;
        lim       = lim_pos;
        mag       = '0;
        for (int k = 0; k < 3; k++)
        begin
            lim    = c_flags[QB].neg[k] ? lim_neg : lim_pos;
            sat[k] = c_quo[QB][k] > lim;
            mag    = sat[k] ? lim : c_quo[QB][k];
            rot_next[k] = c_flags[QB].neg[k] ? -mag[VEC_BITS-1:0] : mag[VEC_BITS-1:0];
            if (c_flags[QB].zero)
                rot_next[k] = '0;
        end
        clip_next = (|sat) && !c_flags[QB].zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (o_adv)
            o_v_reg <= c_valid[QB];
    end

    always_ff @(posedge clk)
    begin
        if (o_adv && c_valid[QB])
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
            zero_reg <= c_flags[QB].zero;
        end
    end

    assign res.valid     = o_v_reg;
    assign res.rot_x     = rot_reg[0];
    assign res.rot_y     = rot_reg[1];
    assign res.rot_z     = rot_reg[2];
    assign res.clipped   = clip_reg;
    assign res.zero_norm = zero_reg;

    a_zero_out : assert property (@(posedge clk) disable iff (!rst_n)
        (o_v_reg && zero_reg) |-> (rot_reg == '0 && !clip_reg))
        else $error("zero-norm result not forced to zero");

    a_clip_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (o_v_reg && clip_reg) |->
            (rot_reg[0] == lim_pos[VEC_BITS-1:0] || rot_reg[0] == lim_neg[VEC_BITS-1:0]
          || rot_reg[1] == lim_pos[VEC_BITS-1:0] || rot_reg[1] == lim_neg[VEC_BITS-1:0]
          || rot_reg[2] == lim_pos[VEC_BITS-1:0] || rot_reg[2] == lim_neg[VEC_BITS-1:0]))
        else $error("clipped result has no component at a bound");

    a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid[QB] && !o_adv) |=> (c_valid[QB] && $stable(c_quo[QB])))
        else $error("divider output changed while held");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives rotation requests with random gaps and receiver stalls; an internal
// quaternion rotation predictor checks every returned vector and its flags.
// ----------------------------------------------------------------------------
typedef struct {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic               clip;
    logic               zn;
} rot_vec_t;

class rotation_scoreboard;
    rot_vec_t pending[$];
    int       errors;

    function automatic logic signed [15:0] round_sat(longint num, longint den, ref logic clip);
        longint mag;
        longint q;
        longint lim;
        bit     neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        lim = neg ? 32768 : 32767;
        if (q > lim)
        begin
            clip = 1'b1;
            q    = lim;
        end
        return 16'(neg ? -q : q);
    endfunction

    function void note_request(logic signed [15:0] qw, logic signed [15:0] qx,
                               logic signed [15:0] qy, logic signed [15:0] qz,
                               logic signed [15:0] vx, logic signed [15:0] vy,
                               logic signed [15:0] vz);
        longint   w, x, y, z, a, b, c, pw, px, py, pz, n;
        rot_vec_t e;
        w = longint'(qw); x = longint'(qx); y = longint'(qy); z = longint'(qz);
        a = longint'(vx); b = longint'(vy); c = longint'(vz);
        e.clip = 1'b0;
        e.zn   = 1'b0;
        if (w == 0 && x == 0 && y == 0 && z == 0)
        begin
            e.rx = '0; e.ry = '0; e.rz = '0; e.zn = 1'b1;
        end
        else
        begin
            pw = -x * a - y * b - z * c;
            px = w * a + y * c - z * b;
            py = w * b - x * c + z * a;
            pz = w * c + x * b - y * a;
            n  = w * w + x * x + y * y + z * z;
            e.rx = round_sat(px * w - pw * x - py * z + pz * y, n, e.clip);
            e.ry = round_sat(py * w - pw * y + px * z - pz * x, n, e.clip);
            e.rz = round_sat(pz * w - pw * z - px * y + py * x, n, e.clip);
        end
        pending.push_back(e);
    endfunction

    function void check_result(rot_vec_t got);
        rot_vec_t e;
        if (pending.size() == 0)
        begin
            $display("%0t unexpected result %p", $realtime, got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.rx !== e.rx || got.ry !== e.ry || got.rz !== e.rz ||
            got.clip !== e.clip || got.zn !== e.zn)
        begin
            $display("%0t mismatch expected %p actual %p", $realtime, e, got);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   idle_cycles = 0;
    rotation_scoreboard board = new();

    qvr_in_if  #(.QUAT_BITS(16), .VEC_BITS(16)) req();
    qvr_out_if #(.VEC_BITS(16))                 res();

    quaternion_vector_rotator dut (.clk(clk), .rst_n(rst_n), .req(req), .res(res));

    always #6 clk = ~clk;

    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;
            3: return 16'hc000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                                logic [15:0] qz, logic [15:0] vx, logic [15:0] vy,
                                logic [15:0] vz);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.quat_w <= qw; req.quat_x <= qx; req.quat_y <= qy; req.quat_z <= qz;
        req.vec_x  <= vx; req.vec_y  <= vy; req.vec_z  <= vz;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(qw, qx, qy, qz, vx, vy, vz);
    endtask

    always @(posedge clk)
    begin
        if (res.valid && res.ready && rst_n)
            board.check_result('{res.rot_x, res.rot_y, res.rot_z, res.clipped, res.zero_norm});
    end

    initial
    begin
        int wait_n;
        res.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            wait_n = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                wait_n = 0;
            if (wait_n != 0)
            begin
                res.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        req.valid <= 1'b0;
        req.quat_w <= '0; req.quat_x <= '0; req.quat_y <= '0; req.quat_z <= '0;
        req.vec_x <= '0; req.vec_y <= '0; req.vec_z <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // zero quaternion, identity, extremes, 90 degree turns
        send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h8000, 16'h7fff);
        send_request(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h0001);
        send_request(16'h2d41, 16'h0000, 16'h0000, 16'h2d41, 16'h1000, 16'h0000, 16'h0000);
        send_request(16'h2d41, 16'h2d41, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000);
        send_request(16'h2d41, 16'h0000, 16'h2d41, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
        send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
        send_request(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
        send_request(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0002, 16'h0003);
        send_request(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001, 16'h0000);
        send_request(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'h5555);
        // clip pressure: large vector with skewed rotation
        send_request(16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(16'h2000, 16'he000, 16'h2000, 16'he000, 16'h8000, 16'h8000, 16'h7fff);
        repeat (1750)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             pick_field(), pick_field(), pick_field());
            else if ($urandom_range(0, 4) == 0)
                send_request(16'($urandom_range(0, 7) - 4), 16'($urandom_range(0, 7) - 4),
                             16'($urandom_range(0, 7) - 4), 16'($urandom_range(0, 7) - 4),
                             pick_field(), pick_field(), pick_field());
            else
                send_request(pick_field(), pick_field(), pick_field(), pick_field(),
                             pick_field(), pick_field(), pick_field());
        end
        req.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
